/* hdl/oaid_pkg.sv */
// Package for the ordered array insert/delete unit.
// Holds field widths, command and status codes, the cell operation and sequencer types.
// No dependencies.
package oaid_pkg;

    // Field widths fixed by the item format.
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int OUT_CNT_W = 7;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_MARK,
        OP_COMPACT
    } cell_op_t;

    // Control bundle sent from the sequencer to the cells.
    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  position;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_COMPACT
    } seq_state_t;

endpackage

/* hdl/oaid_cell.sv */
// One cell of the element chain: stores one element and a hole flag.
// Takes its neighbors' contents to shift up on insert and to close gaps on delete.
// Depends on oaid_pkg.
module oaid_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7,
    parameter int ELEM_W = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  oaid_pkg::cell_ctl_t      ctl,
    input  logic [CNT_W-1:0]         count,
    input  logic [ELEM_W-1:0]        value,
    input  logic [ELEM_W-1:0]        below_elem,
    input  logic                     below_hole,
    input  logic [ELEM_W-1:0]        above_elem,
    input  logic                     above_hole,
    output logic [ELEM_W-1:0]        elem,
    output logic                     hole,
    output logic                     match
);

    localparam int CMP_W = (CNT_W > oaid_pkg::POS_W) ? CNT_W : oaid_pkg::POS_W;
    localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic              hole_reg, hole_next;
    logic [CMP_W-1:0]  pos_ext, cnt_ext;

    assign pos_ext = CMP_W'(ctl.position);
    assign cnt_ext = CMP_W'(count);

    // A live element equal to the delete value.
    assign match = (MY_INDEX < cnt_ext) && (elem_reg == value);

    // Next contents of the cell.
    always_comb begin
        elem_next = elem_reg;
        hole_next = hole_reg;
        unique case (ctl.op)
            oaid_pkg::OP_INSERT: begin
                if (MY_INDEX == pos_ext) begin
                    elem_next = value;
                end else if ((MY_INDEX > pos_ext) && (MY_INDEX <= cnt_ext)) begin
                    elem_next = below_elem;
                end
            end
            oaid_pkg::OP_MARK: begin
                hole_next = match;
            end
            oaid_pkg::OP_COMPACT: begin
                // A hole takes a kept element from above; a kept element
                // over a hole hands itself down and becomes a hole.
                if (hole_reg && !above_hole) begin
                    elem_next = above_elem;
                    hole_next = 1'b0;
                end else if (!hole_reg && below_hole) begin
                    hole_next = 1'b1;
                end
            end
            default: begin
                elem_next = elem_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hole_reg <= 1'b0;
        end else begin
            hole_reg <= hole_next;
        end
    end

    assign elem = elem_reg;
    assign hole = hole_reg;

endmodule

/* hdl/ordered_array_insert_delete_unit.sv */
// Ordered array insert/delete unit: top level with sequencer, cell chain
// and registered result. Depends on oaid_pkg and oaid_cell.
//
// Usage:
//   The s_ channel takes one command item: s_tuser is the command (insert,
//   delete all equal, read) and s_tdata carries the value and position.
//   The m_ channel returns exactly one result item per command with the
//   status, the read element, the element count and the number removed.
//   Insert, read and the unused command finish in the accepting cycle; the
//   result is valid on the next cycle, and a new item can be taken every
//   cycle as long as the receiver takes results.
//   Delete marks matching elements and then lets the cell chain close the
//   gaps in the compact state, one neighbor step per cycle; its result
//   is registered as compaction ends and no item is taken meanwhile.
//   The compaction length is set by the chain depth.
//   A synchronous low aresetn empties the array (count zero) and drops any
//   pending result. Element storage is not cleared.
//   When the receiver stalls, the result is held in the output register
//   and s_tready stays low until it is taken.
module ordered_array_insert_delete_unit #(
    parameter int CAPACITY = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero pad [39]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], read_value[33:2],
                                   // element_count[40:34], removed[47:41]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > oaid_pkg::POS_W) ? CNT_W : oaid_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_CYC = CNT_W'(CAPACITY - 1);

    // Input field unpacking.
    logic [oaid_pkg::CMD_W-1:0]        cmd;
    logic signed [oaid_pkg::VAL_W-1:0] value_in;
    logic [oaid_pkg::POS_W-1:0]        pos_in;
    logic signed [ELEMENT_WIDTH-1:0]   value_elem;

    assign cmd        = s_tuser;
    assign value_in   = s_tdata[31:0];
    assign pos_in     = s_tdata[38:32];
    assign value_elem = ELEMENT_WIDTH'(value_in);

    // Control state.
    oaid_pkg::seq_state_t state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     cyc_reg, cyc_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;
    logic [CAPACITY-1:0]  match_sh_reg, match_sh_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [47:0]          m_tdata_reg, m_tdata_next;

    oaid_pkg::cell_ctl_t  ctl;
    logic                 out_free;
    logic                 accept;
    logic                 last_cyc;
    logic [CMP_W-1:0]     pos_ext, cnt_ext;
    logic                 ins_range_ok, ins_ok;
    logic                 rd_ok;
    logic [CNT_W-1:0]     removed_total;

    // Chain wiring.
    logic [ELEMENT_WIDTH-1:0] elem_w [CAPACITY];
    logic [CAPACITY-1:0]      hole_w;
    logic [CAPACITY-1:0]      match_w;
    logic signed [ELEMENT_WIDTH-1:0] rd_elem;
    logic [oaid_pkg::VAL_W-1:0]      rd_value;

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign last_cyc = (cyc_reg == LAST_CYC);

    assign pos_ext      = CMP_W'(pos_in);
    assign cnt_ext      = CMP_W'(count_reg);
    assign ins_range_ok = (pos_ext <= cnt_ext);
    assign ins_ok       = ins_range_ok && (count_reg != CAP_CNT);
    assign rd_ok        = (pos_ext < cnt_ext);

    // Read selection; the index is only used when it lies below count.
    assign rd_elem  = elem_w[pos_ext[IDX_W-1:0]];
    assign rd_value = oaid_pkg::VAL_W'(rd_elem);

    assign removed_total = removed_reg + CNT_W'(match_sh_reg[0]);

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oaid_pkg::ST_IDLE: begin
                if (accept && (cmd == oaid_pkg::CMD_DELETE)) begin
                    state_next = oaid_pkg::ST_COMPACT;
                end
            end
            oaid_pkg::ST_COMPACT: begin
                if (last_cyc) begin
                    state_next = oaid_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = oaid_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input ready and the operation for the chain.
    always_comb begin
        s_tready     = 1'b0;
        ctl.op       = oaid_pkg::OP_HOLD;
        ctl.position = pos_in;
        unique case (state_reg)
            oaid_pkg::ST_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    if ((cmd == oaid_pkg::CMD_INSERT) && ins_ok) begin
                        ctl.op = oaid_pkg::OP_INSERT;
                    end else if (cmd == oaid_pkg::CMD_DELETE) begin
                        ctl.op = oaid_pkg::OP_MARK;
                    end
                end
            end
            oaid_pkg::ST_COMPACT: begin
                ctl.op = oaid_pkg::OP_COMPACT;
            end
            default: begin
                ctl.op = oaid_pkg::OP_HOLD;
            end
        endcase
    end

    // Count, removal tally and result register.
    always_comb begin
        count_next    = count_reg;
        cyc_next      = cyc_reg;
        removed_next  = removed_reg;
        match_sh_next = match_sh_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (state_reg == oaid_pkg::ST_COMPACT) begin
            cyc_next      = cyc_reg + CNT_W'(1);
            removed_next  = removed_total;
            match_sh_next = match_sh_reg >> 1;
            if (last_cyc) begin
                count_next    = count_reg - removed_total;
                m_tvalid_next = 1'b1;
                m_tdata_next  = {oaid_pkg::OUT_CNT_W'(removed_total),
                                 oaid_pkg::OUT_CNT_W'(count_reg - removed_total),
                                 {oaid_pkg::VAL_W{1'b0}}, oaid_pkg::STAT_OK};
            end
        end else if (accept) begin
            priority case (cmd)
                oaid_pkg::CMD_INSERT: begin
                    m_tvalid_next = 1'b1;
                    if (!ins_range_ok) begin
                        m_tdata_next = {{oaid_pkg::OUT_CNT_W{1'b0}},
                                        oaid_pkg::OUT_CNT_W'(count_reg),
                                        {oaid_pkg::VAL_W{1'b0}}, oaid_pkg::STAT_RANGE};
                    end else if (!ins_ok) begin
                        m_tdata_next = {{oaid_pkg::OUT_CNT_W{1'b0}},
                                        oaid_pkg::OUT_CNT_W'(count_reg),
                                        {oaid_pkg::VAL_W{1'b0}}, oaid_pkg::STAT_FULL};
                    end else begin
                        count_next   = count_reg + CNT_W'(1);
                        m_tdata_next = {{oaid_pkg::OUT_CNT_W{1'b0}},
                                        oaid_pkg::OUT_CNT_W'(count_reg + CNT_W'(1)),
                                        {oaid_pkg::VAL_W{1'b0}}, oaid_pkg::STAT_OK};
                    end
                end
                oaid_pkg::CMD_DELETE: begin
                    // Result follows at the end of compaction.
                    m_tvalid_next = 1'b0;
                    cyc_next      = '0;
                    removed_next  = '0;
                    match_sh_next = match_w;
                end
                oaid_pkg::CMD_READ: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{oaid_pkg::OUT_CNT_W{1'b0}},
                                     oaid_pkg::OUT_CNT_W'(count_reg),
                                     rd_ok ? rd_value : {oaid_pkg::VAL_W{1'b0}},
                                     rd_ok ? oaid_pkg::STAT_OK : oaid_pkg::STAT_RANGE};
                end
                default: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{oaid_pkg::OUT_CNT_W{1'b0}},
                                     oaid_pkg::OUT_CNT_W'(count_reg),
                                     {oaid_pkg::VAL_W{1'b0}}, oaid_pkg::STAT_OK};
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= oaid_pkg::ST_IDLE;
            count_reg    <= '0;
            cyc_reg      <= '0;
            removed_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cyc_reg      <= cyc_next;
            removed_reg  <= removed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        match_sh_reg <= match_sh_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The chain of element cells.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] below_elem, above_elem;
        logic                     below_hole, above_hole;

        if (i == 0) begin : g_bottom
            assign below_elem = '0;
            assign below_hole = 1'b0;
        end else begin : g_inner_lo
            assign below_elem = elem_w[i-1];
            assign below_hole = hole_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign above_elem = '0;
            assign above_hole = 1'b1;
        end else begin : g_inner_hi
            assign above_elem = elem_w[i+1];
            assign above_hole = hole_w[i+1];
        end

        oaid_cell #(
            .INDEX  (i),
            .CNT_W  (CNT_W),
            .ELEM_W (ELEMENT_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .count      (count_reg),
            .value      (value_elem),
            .below_elem (below_elem),
            .below_hole (below_hole),
            .above_elem (above_elem),
            .above_hole (above_hole),
            .elem       (elem_w[i]),
            .hole       (hole_w[i]),
            .match      (match_w[i])
        );
    end

    // The count never exceeds the chain depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("element count above capacity");

    // No item is taken and no result shown while gaps are being closed.
    a_compact_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == oaid_pkg::ST_COMPACT) |-> (!s_tready && !m_tvalid_reg))
        else $error("handshake active during compaction");

    // A finished delete never grows the array.
    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == oaid_pkg::ST_COMPACT && last_cyc) |=>
        (count_reg <= $past(count_reg) && m_tvalid_reg))
        else $error("delete grew the array or lost its result");

    // A successful insert adds exactly one element.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == oaid_pkg::OP_INSERT) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not add one element");

endmodule

/* dv/tb_top.sv */
// Testbench for ordered_array_insert_delete_unit: directed table, then random phases.
// Each result is checked against a typed expectation or a behavioral copy of the array kept here.
// Depends on oaid_pkg and the unit's RTL.
module tb_top;

    localparam int CAPACITY    = 64;
    localparam int ELEM_W      = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int ROWS        = 20;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int RAND_ITEMS  = 950;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = CAPACITY + 16;

    // The fourth command code is unused by the unit and must be ignored.
    localparam logic [oaid_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result item as unpacked from m_tdata.
    typedef struct packed {
        logic [oaid_pkg::STAT_W-1:0]    status;
        logic signed [31:0]             read_value;
        logic [oaid_pkg::OUT_CNT_W-1:0] element_count;
        logic [oaid_pkg::OUT_CNT_W-1:0] removed;
    } array_result_t;

    // One row of the directed table.
    typedef struct packed {
        logic [oaid_pkg::CMD_W-1:0] cmd;
        logic signed [31:0]         value;
        logic [oaid_pkg::POS_W-1:0] position;
        logic                       typed;
        array_result_t              want;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // value[31:0], position[38:32], zero pad [39]
    logic [1:0]  s_tuser = '0;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // status[1:0], read_value[33:2],
                                  // element_count[40:34], removed[47:41]

    // Shadow copy of the array and its fill level.
    logic signed [31:0] elem_store [CAPACITY];
    int                 elem_count;

    array_result_t pending_results[$];
    directed_row_t directed_tab [ROWS];
    int            items_sent;
    int            results_seen = 0;
    int            mismatches = 0;
    int            quiet_cycles = 0;
    bit            tx_gaps;
    bit            rx_stalls;
    int            stall_left;

    ordered_array_insert_delete_unit #(
        .CAPACITY(CAPACITY),
        .ELEMENT_WIDTH(ELEM_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Clock generation.
    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    // Apply one command to the shadow array and return the result it gives.
    function automatic array_result_t apply_array_op(
            input logic [oaid_pkg::CMD_W-1:0] cmd,
            input logic signed [31:0] value,
            input logic [oaid_pkg::POS_W-1:0] position);
        array_result_t r;
        int            w;
        int            i;
        r = '0;
        case (cmd)
            oaid_pkg::CMD_INSERT: begin
                if (position > elem_count) begin
                    r.status = oaid_pkg::STAT_RANGE;
                end else if (elem_count >= CAPACITY) begin
                    r.status = oaid_pkg::STAT_FULL;
                end else begin
                    for (i = elem_count; i > position; i--) begin
                        elem_store[IDX_W'(i)] = elem_store[IDX_W'(i - 1)];
                    end
                    elem_store[IDX_W'(position)] = value;
                    elem_count++;
                end
            end
            oaid_pkg::CMD_DELETE: begin
                w = 0;
                for (i = 0; i < elem_count; i++) begin
                    if (elem_store[IDX_W'(i)] == value) begin
                        r.removed = r.removed + 1'b1;
                    end else begin
                        elem_store[IDX_W'(w)] = elem_store[IDX_W'(i)];
                        w++;
                    end
                end
                elem_count = w;
            end
            oaid_pkg::CMD_READ: begin
                if (position < elem_count) begin
                    r.read_value = elem_store[IDX_W'(position)];
                end else begin
                    r.status = oaid_pkg::STAT_RANGE;
                end
            end
            default: begin
            end
        endcase
        r.element_count = oaid_pkg::OUT_CNT_W'(elem_count);
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, field, want, got);
        mismatches++;
    endtask

    // Offer one item and hold it until accepted, then record what it should produce.
    task automatic send_item(input logic [oaid_pkg::CMD_W-1:0] cmd,
                             input logic signed [31:0] value,
                             input logic [oaid_pkg::POS_W-1:0] position, input bit typed,
                             input array_result_t typed_want);
        array_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, position, value};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_array_op(cmd, value, position);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
    endtask

    // Random gap between items: mostly none, sometimes short, rarely long.
    task automatic pace_sender();
        int r;
        int n;
        n = 0;
        if (tx_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 95) begin
                n = $urandom_range(10, 30);
            end else if (r >= 65) begin
                n = $urandom_range(1, 3);
            end
        end
        if (n > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 40'({$urandom(), $urandom()});
            repeat (n) @(posedge aclk);
        end
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Values come mostly from a small pool so that deletes hit duplicates.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = -32'sd1;
            3: v = 32'sd0;
            4: v = 32'sd17;
            5: v = 32'sh5555_aaaa;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Send a random command with weights given per phase (percent insert, delete, read).
    task automatic send_weighted(input int p_ins, input int p_del, input int p_rd);
        int                         r;
        logic [oaid_pkg::CMD_W-1:0] cmd;
        logic [oaid_pkg::POS_W-1:0] position;
        logic signed [31:0]         value;
        r = $urandom_range(0, 99);
        if (r < p_ins) begin
            cmd = oaid_pkg::CMD_INSERT;
        end else if (r < p_ins + p_del) begin
            cmd = oaid_pkg::CMD_DELETE;
        end else if (r < p_ins + p_del + p_rd) begin
            cmd = oaid_pkg::CMD_READ;
        end else begin
            cmd = CMD_UNUSED;
        end
        // Positions are mostly legal for the current fill level.
        if ($urandom_range(0, 9) == 0) begin
            position = oaid_pkg::POS_W'($urandom_range(0, CAPACITY));
        end else if (cmd == oaid_pkg::CMD_READ && elem_count > 0) begin
            position = oaid_pkg::POS_W'($urandom_range(0, elem_count - 1));
        end else begin
            position = oaid_pkg::POS_W'($urandom_range(0, elem_count));
        end
        // Deletes usually target a stored value.
        if (cmd == oaid_pkg::CMD_DELETE && elem_count > 0 && $urandom_range(0, 3) != 0) begin
            value = elem_store[IDX_W'($urandom_range(0, elem_count - 1))];
        end else begin
            value = pick_value();
        end
        send_item(cmd, value, position, 1'b0, '0);
        pace_sender();
    endtask

    // Empty the array, fill it with one value, try inserts past full and a read, then delete that value.
    task automatic run_uniform_phase();
        logic signed [31:0] v;
        int                 extra;
        while (elem_count > 0) begin
            send_item(oaid_pkg::CMD_DELETE, elem_store[0],
                      oaid_pkg::POS_W'($urandom_range(0, CAPACITY)), 1'b0, '0);
            pace_sender();
        end
        v = pick_value();
        while (elem_count < CAPACITY) begin
            send_item(oaid_pkg::CMD_INSERT, v,
                      oaid_pkg::POS_W'($urandom_range(0, elem_count)), 1'b0, '0);
            pace_sender();
        end
        for (extra = 0; extra < 4; extra++) begin
            send_item(oaid_pkg::CMD_INSERT, pick_value(),
                      oaid_pkg::POS_W'($urandom_range(0, CAPACITY)), 1'b0, '0);
            pace_sender();
        end
        send_item(oaid_pkg::CMD_READ, 32'sd0, oaid_pkg::POS_W'(CAPACITY - 1), 1'b0, '0);
        send_item(oaid_pkg::CMD_DELETE, v,
                  oaid_pkg::POS_W'($urandom_range(0, CAPACITY)), 1'b0, '0);
        pace_sender();
    endtask

    // Receiver: random stalls, switched on and off over the run.
    initial begin
        stall_left = 0;
        rx_stalls = 1'b1;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 299) == 0) begin
                rx_stalls = ~rx_stalls;
            end
            if (stall_left == 0 && rx_stalls) begin
                if ($urandom_range(0, 39) == 0) begin
                    stall_left = $urandom_range(15, 40);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 3);
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        array_result_t got;
        array_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status        = m_tdata[1:0];
            got.read_value    = m_tdata[33:2];
            got.element_count = m_tdata[40:34];
            got.removed       = m_tdata[47:41];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", '0, 32'(got.status));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, got.read_value);
                if (got.element_count !== want.element_count)
                    report_mismatch("element_count", 32'(want.element_count),
                                    32'(got.element_count));
                if (got.removed !== want.removed)
                    report_mismatch("removed", 32'(want.removed), 32'(got.removed));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Directed table: typed expectations where they are obvious, else predicted.
    initial begin
        directed_tab[0]  = '{oaid_pkg::CMD_READ,   32'sd0,          7'd0,  1'b1,
                             '{oaid_pkg::STAT_RANGE, 32'sd0, 7'd0, 7'd0}};
        directed_tab[1]  = '{oaid_pkg::CMD_DELETE, 32'sd0,          7'd0,  1'b1,
                             '{oaid_pkg::STAT_OK, 32'sd0, 7'd0, 7'd0}};
        directed_tab[2]  = '{oaid_pkg::CMD_INSERT, 32'sd5,          7'd1,  1'b1,
                             '{oaid_pkg::STAT_RANGE, 32'sd0, 7'd0, 7'd0}};
        directed_tab[3]  = '{oaid_pkg::CMD_INSERT, 32'sh8000_0000,  7'd0,  1'b1,
                             '{oaid_pkg::STAT_OK, 32'sd0, 7'd1, 7'd0}};
        directed_tab[4]  = '{oaid_pkg::CMD_INSERT, 32'sh7fff_ffff,  7'd1,  1'b1,
                             '{oaid_pkg::STAT_OK, 32'sd0, 7'd2, 7'd0}};
        directed_tab[5]  = '{oaid_pkg::CMD_READ,   32'sd0,          7'd0,  1'b1,
                             '{oaid_pkg::STAT_OK, 32'sh8000_0000, 7'd2, 7'd0}};
        directed_tab[6]  = '{oaid_pkg::CMD_READ,   32'sd0,          7'd1,  1'b1,
                             '{oaid_pkg::STAT_OK, 32'sh7fff_ffff, 7'd2, 7'd0}};
        directed_tab[7]  = '{oaid_pkg::CMD_READ,   32'sd0,          7'd2,  1'b1,
                             '{oaid_pkg::STAT_RANGE, 32'sd0, 7'd2, 7'd0}};
        directed_tab[8]  = '{CMD_UNUSED,           -32'sd1,         7'd64, 1'b1,
                             '{oaid_pkg::STAT_OK, 32'sd0, 7'd2, 7'd0}};
        directed_tab[9]  = '{oaid_pkg::CMD_INSERT, -32'sd1,         7'd1,  1'b0, '0};
        directed_tab[10] = '{oaid_pkg::CMD_INSERT, -32'sd1,         7'd0,  1'b0, '0};
        directed_tab[11] = '{oaid_pkg::CMD_INSERT, 32'sd0,          7'd4,  1'b0, '0};
        directed_tab[12] = '{oaid_pkg::CMD_INSERT, 32'sd7,          7'd64, 1'b1,
                             '{oaid_pkg::STAT_RANGE, 32'sd0, 7'd5, 7'd0}};
        directed_tab[13] = '{oaid_pkg::CMD_READ,   32'sd0,          7'd64, 1'b1,
                             '{oaid_pkg::STAT_RANGE, 32'sd0, 7'd5, 7'd0}};
        directed_tab[14] = '{oaid_pkg::CMD_DELETE, 32'sd12345,      7'd0,  1'b1,
                             '{oaid_pkg::STAT_OK, 32'sd0, 7'd5, 7'd0}};
        directed_tab[15] = '{oaid_pkg::CMD_DELETE, -32'sd1,         7'd3,  1'b1,
                             '{oaid_pkg::STAT_OK, 32'sd0, 7'd3, 7'd2}};
        directed_tab[16] = '{oaid_pkg::CMD_READ,   32'sd0,          7'd0,  1'b0, '0};
        directed_tab[17] = '{oaid_pkg::CMD_READ,   32'sd0,          7'd2,  1'b0, '0};
        directed_tab[18] = '{oaid_pkg::CMD_DELETE, 32'sh8000_0000,  7'd0,  1'b0, '0};
        directed_tab[19] = '{CMD_UNUSED,           32'sh7fff_ffff,  7'd127, 1'b0, '0};
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial begin
        int            phase_kind;
        int            phase_len;
        int            i;
        bit            paused_once;
        directed_row_t row;
        elem_count   = 0;
        items_sent   = 0;
        paused_once  = 1'b0;
        tx_gaps      = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < ROWS; i++) begin
            row = directed_tab[ROW_W'(i)];
            send_item(row.cmd, row.value, row.position, row.typed, row.want);
            pace_sender();
        end

        // Random phases: filling, draining, uniform fill-and-clear, and noise.
        while (items_sent < ROWS + RAND_ITEMS) begin
            phase_kind = $urandom_range(0, 9);
            phase_len  = $urandom_range(20, 90);
            tx_gaps    = ($urandom_range(0, 3) != 0);
            if (phase_kind < 4) begin
                for (i = 0; i < phase_len; i++) send_weighted(75, 8, 12);
            end else if (phase_kind < 6) begin
                for (i = 0; i < phase_len; i++) send_weighted(20, 45, 25);
            end else if (phase_kind < 8) begin
                run_uniform_phase();
            end else begin
                for (i = 0; i < phase_len; i++) begin
                    send_item(oaid_pkg::CMD_W'($urandom_range(0, 3)), $urandom(),
                              oaid_pkg::POS_W'($urandom_range(0, CAPACITY)), 1'b0, '0);
                    pace_sender();
                end
            end
            // After the first phase and at random later, the sender holds off until all is answered.
            if (!paused_once || $urandom_range(0, 3) == 0) begin
                wait_results_drained();
                paused_once = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/oaid_pkg.sv
hdl/oaid_cell.sv
hdl/ordered_array_insert_delete_unit.sv
dv/tb_top.sv
